>>> rtl/core/abob_pkg.sv
// Shared constants, codes and stage payload types of the ARGB-over-BGR555 blender.
`default_nettype none

package abob_pkg;

    // Alpha codes that take the bypass path.
    localparam logic [7:0] ALPHA_CLEAR  = 8'h00;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hff;
    // Full weight: the destination weight is ALPHA_ONE minus alpha.
    localparam logic [8:0] ALPHA_ONE    = 9'h100;

    // Saturated 5-bit channel value.
    localparam logic [4:0] CHAN_MAX = 5'h1f;

    // Channel slots, ordered so that a packed channel vector is BGR555.
    localparam int CH_R = 0;
    localparam int CH_G = 1;
    localparam int CH_B = 2;

    // Per-pixel mode codes.
    localparam logic [1:0] MODE_BLEND = 2'd0;
    localparam logic [1:0] MODE_COPY  = 2'd1;
    localparam logic [1:0] MODE_KEEP  = 2'd2;

    typedef logic [2:0][4:0] chan5_t;

    // Payload of the decode stage.
    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  alpha;
        logic [8:0]  dst_weight;
        chan5_t      src5;
        chan5_t      dst5;
        logic [14:0] bypass_pixel;
    } dec_t;

    // Payload of the multiply stage.
    typedef struct packed {
        logic [1:0]        mode;
        logic [2:0][13:0]  prod_dst;
        logic [2:0][12:0]  prod_src;
        logic [14:0]       bypass_pixel;
    } mul_t;

endpackage : abob_pkg

`default_nettype wire

>>> rtl/core/abob_decode.sv
// First pipeline stage: splits the pixels into channels and classifies the alpha.
`default_nettype none

module abob_decode
    import abob_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] src_pixel,
    input  wire logic [15:0] dst_pixel,
    output logic             out_valid,
    input  wire logic        out_ready,
    output dec_t             out_data
);

    logic valid_reg, valid_next;
    dec_t data_reg, data_next;

    assign in_ready = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_comb begin
        data_next.alpha        = src_pixel[31:24];
        data_next.dst_weight   = ALPHA_ONE - {1'b0, src_pixel[31:24]};
        data_next.src5[CH_R]   = src_pixel[23:19];
        data_next.src5[CH_G]   = src_pixel[15:11];
        data_next.src5[CH_B]   = src_pixel[7:3];
        data_next.dst5[CH_R]   = dst_pixel[4:0];
        data_next.dst5[CH_G]   = dst_pixel[9:5];
        data_next.dst5[CH_B]   = dst_pixel[14:10];
        if (src_pixel[31:24] == ALPHA_OPAQUE) begin
            data_next.mode         = MODE_COPY;
            data_next.bypass_pixel = data_next.src5;
        end else if (src_pixel[31:24] == ALPHA_CLEAR) begin
            data_next.mode         = MODE_KEEP;
            data_next.bypass_pixel = dst_pixel[14:0];
        end else begin
            data_next.mode         = MODE_BLEND;
            data_next.bypass_pixel = dst_pixel[14:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule : abob_decode

`default_nettype wire

>>> rtl/core/abob_mul.sv
// Second pipeline stage: weights source by alpha and destination by dst_weight.
`default_nettype none

module abob_mul
    import abob_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    output logic      in_ready,
    input  dec_t      in_data,
    output logic      out_valid,
    input  wire logic out_ready,
    output mul_t      out_data
);

    logic valid_reg, valid_next;
    mul_t data_reg, data_next;

    assign in_ready = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_comb begin
        data_next.mode         = in_data.mode;
        data_next.bypass_pixel = in_data.bypass_pixel;
        for (int c = 0; c < 3; c++) begin
            data_next.prod_dst[c] = 14'(in_data.dst_weight) * 14'(in_data.dst5[c]);
            data_next.prod_src[c] = 13'(in_data.alpha) * 13'(in_data.src5[c]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule : abob_mul

`default_nettype wire

>>> rtl/core/abob_sat.sv
// Third pipeline stage: sums, scales and saturates the channels into the output register.
`default_nettype none

module abob_sat
    import abob_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   in_valid,
    output logic        in_ready,
    input  mul_t        in_data,
    output logic        out_valid,
    input  wire logic   out_ready,
    output logic [14:0] out_pixel,
    output logic        write_flag
);

    logic        valid_reg, valid_next;
    logic [14:0] pixel_reg, pixel_next;
    logic        flag_reg, flag_next;
    chan5_t      blend;
    logic [9:0]  sum_r;
    logic [9:0]  sum_b;
    logic [14:0] sum_g;

    assign in_ready = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_comb begin
        // Red and blue drop the five lowest product bits and keep three fractional bits.
        sum_r = {1'b0, in_data.prod_dst[CH_R][13:5]} + {2'b00, in_data.prod_src[CH_R][12:5]};
        sum_b = {1'b0, in_data.prod_dst[CH_B][13:5]} + {2'b00, in_data.prod_src[CH_B][12:5]};
        // Green is summed at full precision; bit 13 and above means overflow.
        sum_g = {1'b0, in_data.prod_dst[CH_G]} + {2'b00, in_data.prod_src[CH_G]};

        blend[CH_R] = (sum_r[9:8] != 2'b00) ? CHAN_MAX : sum_r[7:3];
        blend[CH_B] = (sum_b[9:8] != 2'b00) ? CHAN_MAX : sum_b[7:3];
        blend[CH_G] = (sum_g[14:13] != 2'b00) ? CHAN_MAX : sum_g[12:8];

        pixel_next = (in_data.mode == MODE_BLEND) ? blend : in_data.bypass_pixel;
        flag_next  = (in_data.mode != MODE_KEEP);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            pixel_reg <= pixel_next;
            flag_reg  <= flag_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_pixel  = pixel_reg;
    assign write_flag = flag_reg;

endmodule : abob_sat

`default_nettype wire

>>> rtl/core/argb_over_bgr555_blend.sv
// Top level of the ARGB8888-over-BGR555 alpha blender: three-stage pipeline.
//
// The input channel (s_valid, s_ready) carries one transaction per pixel: an
// ARGB8888 source pixel and the BGR555 destination pixel under it. The result
// channel (m_valid, m_ready) returns one transaction per input, in order, with
// the blended BGR555 pixel and a write flag that is low for a fully
// transparent source, where the destination comes back unchanged.
// Decode, multiply, and sum/saturate each end in a register, so an input
// passes through the decode, multiply and output registers in turn before
// m_valid rises with its result.
// Throughput is one pixel per clock as long as m_ready stays high; it is set
// by the six multipliers of the multiply stage working in parallel, with
// every stage taking a new pixel each cycle unless the receiver stalls.
// Each stage holds its own valid bit and is ready whenever it is empty or its
// successor takes its content. When the receiver stalls, the output register
// holds its transaction and the earlier stages keep filling until every stage
// is occupied; only then does s_ready drop. Nothing is lost or repeated.
// Synchronous active-low reset clears all valid bits, so the pipeline comes up
// empty with m_valid low; payload registers are not reset.
`default_nettype none

module argb_over_bgr555_blend
    import abob_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_src_pixel,
    input  wire logic [15:0] s_dst_pixel,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [14:0]      m_out_pixel,
    output logic             m_write_flag
);

    // Stage-to-stage handshake and payload.
    logic dec_valid, dec_ready;
    dec_t dec_data;
    logic mul_valid, mul_ready;
    mul_t mul_data;

    // Decode splits channels, forms the destination weight and picks a mode.
    abob_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .src_pixel (s_src_pixel),
        .dst_pixel (s_dst_pixel),
        .out_valid (dec_valid),
        .out_ready (dec_ready),
        .out_data  (dec_data)
    );

    // Multiply weights all six channel values at once.
    abob_mul u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (dec_valid),
        .in_ready  (dec_ready),
        .in_data   (dec_data),
        .out_valid (mul_valid),
        .out_ready (mul_ready),
        .out_data  (mul_data)
    );

    // The last stage is also the output register of the result channel.
    abob_sat u_sat (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (mul_valid),
        .in_ready   (mul_ready),
        .in_data    (mul_data),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_pixel  (m_out_pixel),
        .write_flag (m_write_flag)
    );

endmodule : argb_over_bgr555_blend

`default_nettype wire

>>> rtl/core/abob_checker.sv
// Port-level checker for the blender, bound to its top level.
`default_nettype none

module abob_checker
    import abob_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic [31:0] s_src_pixel,
    input wire logic [15:0] s_dst_pixel,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [14:0] m_out_pixel,
    input wire logic        m_write_flag
);

    // The pipeline comes out of reset empty.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // A stalled result transaction keeps its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_pixel) && $stable(m_write_flag))
        else $error("stalled result changed");

    // A transparent pixel with a free-running receiver returns the destination.
    a_transparent: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_src_pixel[31:24] == ALPHA_CLEAR) ##1 m_ready ##1 m_ready
        |=> m_valid && !m_write_flag && m_out_pixel == $past(s_dst_pixel[14:0], 3))
        else $error("transparent pixel mishandled");

    // An opaque pixel with a free-running receiver returns the truncated source.
    a_opaque: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_src_pixel[31:24] == ALPHA_OPAQUE) ##1 m_ready ##1 m_ready
        |=> m_valid && m_write_flag
            && m_out_pixel[14:10] == $past(s_src_pixel[7:3], 3)
            && m_out_pixel[9:5] == $past(s_src_pixel[15:11], 3)
            && m_out_pixel[4:0] == $past(s_src_pixel[23:19], 3))
        else $error("opaque pixel mishandled");

endmodule : abob_checker

bind argb_over_bgr555_blend abob_checker u_abob_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_src_pixel  (s_src_pixel),
    .s_dst_pixel  (s_dst_pixel),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_out_pixel  (m_out_pixel),
    .m_write_flag (m_write_flag)
);

`default_nettype wire
